/* rtl/t1brc_pkg.sv */
// ----------------------------------------------------------------------------
// t1brc_pkg
// Shared types, codes and the byte-wide CRC-16 step for the T=1 block checker.
// ----------------------------------------------------------------------------
package t1brc_pkg;

  // largest information field accepted in a block
  localparam int unsigned MAX_INF = 254;

  localparam int unsigned POS_W = 9;

  // role of each echoed byte
  typedef enum logic [1:0] {
    ROLE_HEADER = 2'd0,
    ROLE_INFO   = 2'd1,
    ROLE_CHECK  = 2'd2,
    ROLE_TRAIL  = 2'd3
  } role_t;

  // frame status; the fault register reuses these codes
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_SHORT    = 3'd1,
    ST_LEN_BIG  = 3'd2,
    ST_TRUNC    = 3'd3,
    ST_MISMATCH = 3'd4
  } status_t;

  // block type from the PCB
  typedef enum logic [1:0] {
    KIND_I = 2'd0,
    KIND_R = 2'd1,
    KIND_S = 2'd2
  } kind_t;

  // one result transaction
  typedef struct packed {
    logic [7:0] out_byte;
    role_t      byte_role;
    logic       frame_done;
    status_t    status;
    logic [7:0] node_address;
    logic [7:0] control_byte;
    logic [7:0] info_length;
    kind_t      block_kind;
    logic       sequence_bit;
    logic       more_bit;
    logic       r_error_free;
  } result_t;

  // crc-16, poly 0x1021, msb first, one byte per call
  function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
    logic [7:0]  t;
    logic [7:0]  q;
    logic [15:0] c;
    t = crc[15:8] ^ b;
    q = t ^ {4'b0000, t[7:4]};
    c = {crc[7:0], 8'h00};
    c = c ^ {8'h00, q};
    c = c ^ {3'b000, q, 5'b00000};
    c = c ^ {q[3:0], 12'h000};
    return c;
  endfunction

endpackage

/* rtl/t1brc_frame.sv */
// ----------------------------------------------------------------------------
// t1brc_frame
// Frame state and per-byte decode: roles, LRC/CRC check, status and PCB fields.
// ----------------------------------------------------------------------------
module t1brc_frame import t1brc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,
  input  logic       in_accept,
  input  logic [7:0] rx_byte,
  input  logic       last_byte,
  output result_t    res
);

  logic             edc_mode;
  logic [POS_W-1:0] byte_position;
  logic [7:0]       len_store;
  logic [7:0]       nad_store;
  logic [7:0]       pcb_store;
  logic [7:0]       lrc_accum;
  logic [15:0]      crc_accum;
  status_t          fault_code;
  logic             block_complete;

  logic [POS_W-1:0] byte_position_next;
  logic [7:0]       len_store_next;
  logic [7:0]       nad_store_next;
  logic [7:0]       pcb_store_next;
  logic [7:0]       lrc_accum_next;
  logic [15:0]      crc_accum_next;
  status_t          fault_code_next;
  logic             block_complete_next;

  logic [POS_W-1:0] check_start;
  logic             bad;
  role_t            role;
  status_t          status;
  kind_t            kind;
  logic             seq;
  logic             more;
  logic             rfree;

  assign check_start = POS_W'(3) + {1'b0, len_store};

  // byte classification and state update
  always_comb begin
    nad_store_next      = nad_store;
    pcb_store_next      = pcb_store;
    len_store_next      = len_store;
    lrc_accum_next      = lrc_accum;
    crc_accum_next      = crc_accum;
    fault_code_next     = fault_code;
    block_complete_next = block_complete;
    bad                 = 1'b0;
    byte_position_next  = (byte_position == {POS_W{1'b1}}) ? byte_position
                                                          : byte_position + POS_W'(1);
    if (block_complete || (fault_code == ST_LEN_BIG)) begin
      role = ROLE_TRAIL;
    end else if (byte_position < POS_W'(3)) begin
      role = ROLE_HEADER;
      case (byte_position[1:0])
        2'd0: begin
          nad_store_next = rx_byte;
        end
        2'd1: begin
          pcb_store_next = rx_byte;
        end
        default: begin
          len_store_next = rx_byte;
          if (rx_byte > 8'(MAX_INF)) begin
            fault_code_next = ST_LEN_BIG;
          end
        end
      endcase
      lrc_accum_next = lrc_accum ^ rx_byte;
      crc_accum_next = crc_update(crc_accum, rx_byte);
    end else if (byte_position < check_start) begin
      role           = ROLE_INFO;
      lrc_accum_next = lrc_accum ^ rx_byte;
      crc_accum_next = crc_update(crc_accum, rx_byte);
    end else begin
      role = ROLE_CHECK;
      if (edc_mode) begin
        bad                 = (rx_byte != lrc_accum);
        block_complete_next = 1'b1;
      end else if (byte_position == check_start) begin
        bad = (rx_byte != crc_accum[15:8]);
      end else begin
        bad                 = (rx_byte != crc_accum[7:0]);
        block_complete_next = 1'b1;
      end
      if (bad && (fault_code == ST_OK)) begin
        fault_code_next = ST_MISMATCH;
      end
    end
  end

  // closing status on the last byte
  always_comb begin
    status = ST_OK;
    if (last_byte) begin
      if (byte_position_next < POS_W'(3)) begin
        status = ST_SHORT;
      end else if (fault_code_next == ST_LEN_BIG) begin
        status = ST_LEN_BIG;
      end else if (!block_complete_next) begin
        status = ST_TRUNC;
      end else if (fault_code_next == ST_MISMATCH) begin
        status = ST_MISMATCH;
      end
    end
  end

  // pcb decode
  always_comb begin
    seq   = 1'b0;
    more  = 1'b0;
    rfree = 1'b0;
    if (!pcb_store_next[7]) begin
      kind = KIND_I;
      seq  = pcb_store_next[6];
      more = pcb_store_next[5];
    end else if (!pcb_store_next[6]) begin
      kind  = KIND_R;
      seq   = pcb_store_next[4];
      rfree = (pcb_store_next[3:0] == 4'h0);
    end else begin
      kind = KIND_S;
    end
  end

  // result of the current transaction
  always_comb begin
    res.out_byte     = rx_byte;
    res.byte_role    = role;
    res.frame_done   = last_byte;
    res.status       = status;
    res.node_address = nad_store_next;
    res.control_byte = pcb_store_next;
    res.info_length  = len_store_next;
    res.block_kind   = kind;
    res.sequence_bit = seq;
    res.more_bit     = more;
    res.r_error_free = rfree;
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      edc_mode <= 1'b1;
    end else if (cfg_wr_en) begin
      edc_mode <= cfg_wr_data;
    end
  end

  // frame state, cleared after the last byte
  always_ff @(posedge clk) begin
    if (rst || (in_accept && last_byte)) begin
      byte_position  <= '0;
      len_store      <= '0;
      nad_store      <= '0;
      pcb_store      <= '0;
      lrc_accum      <= '0;
      crc_accum      <= 16'hFFFF;
      fault_code     <= ST_OK;
      block_complete <= 1'b0;
    end else if (in_accept) begin
      byte_position  <= byte_position_next;
      len_store      <= len_store_next;
      nad_store      <= nad_store_next;
      pcb_store      <= pcb_store_next;
      lrc_accum      <= lrc_accum_next;
      crc_accum      <= crc_accum_next;
      fault_code     <= fault_code_next;
      block_complete <= block_complete_next;
    end
  end

`ifndef NO_ASSERTIONS
  // closing byte returns the frame state to idle
  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    in_accept && last_byte |=> (byte_position == '0) && (fault_code == ST_OK)
                               && !block_complete && (crc_accum == 16'hFFFF))
    else $error("frame state not cleared after last byte");

  // a complete block has at least a header and one check byte
  a_complete_pos: assert property (@(posedge clk) disable iff (rst)
    block_complete |-> (byte_position >= POS_W'(4)))
    else $error("block complete before any check byte");

  // status is only reported on the closing byte
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    in_accept && !last_byte |-> (res.status == ST_OK))
    else $error("status reported on a non-final byte");

  // a length fault is never overwritten by a mismatch
  a_len_sticky: assert property (@(posedge clk) disable iff (rst)
    in_accept && !last_byte && (fault_code == ST_LEN_BIG) |=> (fault_code == ST_LEN_BIG))
    else $error("length fault lost within a frame");
`endif

endmodule

/* rtl/t1brc_out_buf.sv */
// ----------------------------------------------------------------------------
// t1brc_out_buf
// Output register with a skid stage so the input side keeps flowing.
// ----------------------------------------------------------------------------
module t1brc_out_buf import t1brc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  output logic    push_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  logic    main_valid;
  logic    skid_valid;
  result_t main_data;
  result_t skid_data;

  assign push_ready = !skid_valid;
  assign out_valid  = main_valid;
  assign out_data   = main_data;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_ready || !main_valid) begin
      main_valid <= skid_valid || push;
      skid_valid <= 1'b0;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (out_ready || !main_valid) begin
      main_data <= skid_valid ? skid_data : push_data;
    end else if (push) begin
      skid_data <= push_data;
    end
  end

endmodule

/* rtl/t1_block_receive_checker_unit.sv */
// ----------------------------------------------------------------------------
// t1_block_receive_checker_unit
// Byte-stream checker for received ISO 7816 T=1 blocks.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one received byte per transaction; tlast marks the final
//   byte of the response. m_axis returns one result per input byte: the byte
//   echoed with its role (tuser), and on the tlast result the frame status
//   plus the NAD, PCB, LEN and decoded PCB fields.
//   cfg_wr_en/cfg_wr_data set the check code: 1 = LRC, 0 = CRC-16. Change it
//   only between frames.
//   Results are registered in the output register, or in the skid entry while
//   m_axis stalls. Throughput: one byte per cycle while s_axis_tready is high;
//   the CRC and XOR update for a byte is combinational in the frame decode logic.
//   Reset: the check code returns to LRC and the frame state is cleared; no
//   result is pending.
//   Stall: the output register plus one skid entry hold two results; with
//   both full s_axis_tready drops until m_axis_tready takes one.
// ----------------------------------------------------------------------------
module t1_block_receive_checker_unit import t1brc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] out_byte, [10:8] status, [18:11] node_address, [26:19] control_byte,
  // [34:27] info_length, [36:35] block_kind, [37] sequence_bit, [38] more_bit,
  // [39] r_error_free
  output logic [39:0] m_axis_tdata,
  output logic [1:0]  m_axis_tuser,   // [1:0] byte_role
  output logic        m_axis_tlast
);

  logic    in_accept;
  result_t step_res;
  result_t out_res;

  assign in_accept = s_axis_tvalid && s_axis_tready;

  t1brc_frame u_frame (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_accept   (in_accept),
    .rx_byte     (s_axis_tdata),
    .last_byte   (s_axis_tlast),
    .res         (step_res)
  );

  t1brc_out_buf u_out_buf (
    .clk        (clk),
    .rst        (rst),
    .push       (in_accept),
    .push_data  (step_res),
    .push_ready (s_axis_tready),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_data   (out_res)
  );

  // result packing
  assign m_axis_tdata = {out_res.r_error_free, out_res.more_bit, out_res.sequence_bit,
                         out_res.block_kind, out_res.info_length, out_res.control_byte,
                         out_res.node_address, out_res.status, out_res.out_byte};
  assign m_axis_tuser = out_res.byte_role;
  assign m_axis_tlast = out_res.frame_done;

endmodule
